// ===== rtl/ott_pkg.sv =====
// Shared types, codes and sizes for the one-shot timer table.
`timescale 1ns / 1ps
package ott_pkg;

  localparam int TIMER_COUNT = 64;
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int ID_W = 7;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_KILL = 2'd1,
    CMD_POLL = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SET_OK  = 3'd0,
    ST_KILL_OK = 3'd1,
    ST_REJECT  = 3'd2,
    ST_FIRED   = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FINAL = 2'd2
  } state_e;

  typedef struct packed {
    logic              wr_en;
    logic              wr_arm;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_deadline;
    logic              wr_handler;
    logic              advance;
    logic [TIME_W-1:0] now;
  } cell_ctl_t;

endpackage

// ===== rtl/ott_req_if.sv =====
// Request channel of the one-shot timer table.
`timescale 1ns / 1ps
interface ott_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [6:0]  timer_id;
  logic [31:0] delay_ms;
  logic [31:0] now_ms;
  logic        has_handler;

  modport source (output valid, command, timer_id, delay_ms, now_ms, has_handler,
                  input ready);
  modport sink (input valid, command, timer_id, delay_ms, now_ms, has_handler,
                output ready);
endinterface

// ===== rtl/ott_rsp_if.sv =====
// Response channel of the one-shot timer table.
`timescale 1ns / 1ps
interface ott_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] result_id;
  logic       last;

  modport source (output valid, status, result_id, last, input ready);
  modport sink (input valid, status, result_id, last, output ready);
endinterface

// ===== rtl/ott_cell.sv =====
// One timer entry of the table, with its slot in the scan token chain.
`timescale 1ns / 1ps
module ott_cell import ott_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  cell_ctl_t        ctl_i,
  input  logic             tok_i,
  output logic             tok_o,
  output logic             hit_o
);

  logic [TIME_W-1:0] dl_q, dl_d;
  logic              en_q, en_d;
  logic              hnd_q, hnd_d;
  logic              tok_q, tok_d;
  logic              expire;

  assign expire = tok_q && en_q && (dl_q != '0) && (ctl_i.now >= dl_q);
  assign hit_o  = expire && hnd_q;
  assign tok_o  = tok_q;

  always_comb begin
    dl_d  = dl_q;
    en_d  = en_q;
    hnd_d = hnd_q;
    tok_d = tok_q;
    if (ctl_i.wr_en && (ctl_i.wr_idx == cell_idx_i)) begin
      dl_d  = ctl_i.wr_arm ? ctl_i.wr_deadline : '0;
      en_d  = ctl_i.wr_arm;
      hnd_d = ctl_i.wr_arm && ctl_i.wr_handler;
    end
    if (ctl_i.advance) begin
      tok_d = tok_i;
      if (expire) begin
        dl_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q  <= '0;
      en_q  <= 1'b0;
      hnd_q <= 1'b0;
      tok_q <= 1'b0;
    end else begin
      dl_q  <= dl_d;
      en_q  <= en_d;
      hnd_q <= hnd_d;
      tok_q <= tok_d;
    end
  end

endmodule

// ===== rtl/one_shot_timer_table.sv =====
// Top level of the one-shot timer table: command decode, scan control and output register.
`timescale 1ns / 1ps
// A set or kill request is answered with a single response. A poll sends a token
// down the row of 64 timer cells, one cell per cycle unless the scan stalls: it
// stalls when a timer with a handler expires while an earlier fired response is
// still pending and the response register is not free. A final state then sends the
// closing response once that register is free. Each expired timer with a handler
// yields one fired response, and the last response of a poll carries last set.
// No new request is taken while a poll is in progress or while a response waits.
module one_shot_timer_table import ott_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  ott_req_if.sink   req_i,
  ott_rsp_if.source rsp_o
);

  localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(TIMER_COUNT);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]  pend_id_q, pend_id_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_last_q, out_last_d;

  cell_ctl_t              ctl;
  logic [TIMER_COUNT:0]   tok;
  logic                   tok_head;
  logic [TIMER_COUNT-1:0] hit;
  logic                   hit_any;
  logic                   out_free;
  logic                   push;
  logic                   id_ok;
  logic                   advance;

  assign tok[0]   = tok_head;
  assign hit_any  = |hit;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign id_ok    = req_i.timer_id < ID_LIMIT;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    ott_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .ctl_i      (ctl),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .hit_o      (hit[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    now_d        = now_q;
    push         = 1'b0;
    out_status_d = ST_NONE;
    out_id_d     = '0;
    out_last_d   = 1'b1;
    advance      = 1'b0;
    tok_head     = 1'b0;
    req_i.ready  = 1'b0;
    ctl             = '0;
    ctl.now         = now_q;
    ctl.wr_idx      = req_i.timer_id[IDX_W-1:0];
    ctl.wr_deadline = req_i.now_ms + req_i.delay_ms;
    ctl.wr_handler  = req_i.has_handler;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = out_free;
        if (req_i.valid && out_free) begin
          unique case (req_i.command)
            CMD_SET: begin
              push       = 1'b1;
              out_id_d   = req_i.timer_id;
              ctl.wr_en  = id_ok;
              ctl.wr_arm = 1'b1;
              out_status_d = id_ok ? ST_SET_OK : ST_REJECT;
            end
            CMD_KILL: begin
              push       = 1'b1;
              out_id_d   = req_i.timer_id;
              ctl.wr_en  = id_ok;
              ctl.wr_arm = 1'b0;
              out_status_d = id_ok ? ST_KILL_OK : ST_REJECT;
            end
            CMD_POLL: begin
              tok_head     = 1'b1;
              advance      = 1'b1;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              now_d        = req_i.now_ms;
              state_d      = S_SCAN;
            end
            default: begin
              push         = 1'b1;
              out_id_d     = req_i.timer_id;
              out_status_d = ST_REJECT;
            end
          endcase
        end
      end
      S_SCAN: begin
        advance = !(hit_any && pend_valid_q && !out_free);
        if (advance) begin
          idx_d = idx_q + 1'b1;
          if (hit_any) begin
            pend_valid_d = 1'b1;
            pend_id_d    = idx_q;
            if (pend_valid_q) begin
              push         = 1'b1;
              out_status_d = ST_FIRED;
              out_id_d     = ID_W'(pend_id_q);
              out_last_d   = 1'b0;
            end
          end
          if (tok[TIMER_COUNT]) begin
            state_d = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          push         = 1'b1;
          out_status_d = pend_valid_q ? ST_FIRED : ST_NONE;
          out_id_d     = pend_valid_q ? ID_W'(pend_id_q) : '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    ctl.advance = advance;
    out_valid_d = push ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    now_q     <= now_d;
    if (push) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.result_id = out_id_q;
  assign rsp_o.last      = out_last_q;

  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok[TIMER_COUNT:1]))
    else $error("More than one scan token in the cell row.");

  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (tok[TIMER_COUNT:1] == '0))
    else $error("Request taken while a poll scan is in progress.");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("Response register overwritten before it was taken.");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && out_free) |=> (rsp_o.valid && rsp_o.last))
    else $error("Poll closed without a final response.");

endmodule

// ===== bench/one_shot_timer_table_tb.sv =====
// Self-checking testbench for the one-shot timer table with directed and random requests.
`timescale 1ns / 1ps
module one_shot_timer_table_tb import ott_pkg::*;;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 500000;
  localparam int TAIL = 100;
  localparam int N_DIR = 20;
  localparam int HOLD_OFF = 400;

  typedef struct {
    logic [1:0]  command;
    logic [6:0]  timer_id;
    logic [31:0] delay_ms;
    logic [31:0] now_ms;
    logic        has_handler;
  } timer_req_t;

  typedef struct {
    status_e    status;
    logic [6:0] result_id;
    logic       last;
  } timer_rsp_t;

  typedef struct {
    timer_req_t req;
    bit         typed;
    status_e    status;
    logic [6:0] result_id;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ott_req_if req_if ();
  ott_rsp_if rsp_if ();

  one_shot_timer_table uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [31:0] deadline_mdl [TIMER_COUNT];
  bit          armed_mdl [TIMER_COUNT];
  bit          handler_mdl [TIMER_COUNT];
  timer_rsp_t  pending_rsp [$];
  dir_row_t    dir_rows [N_DIR];
  logic [31:0] cur_now = '0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int rsp_seen = 0;
  int fired_seen = 0;
  int reject_seen = 0;
  int req_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the responses of one request and updates the timer state.
  function automatic void timer_step(input timer_req_t r, ref timer_rsp_t res [$]);
    res.delete();
    if (r.command == CMD_POLL) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        if (armed_mdl[i] && deadline_mdl[i] != '0 && r.now_ms >= deadline_mdl[i]) begin
          deadline_mdl[i] = '0;
          if (handler_mdl[i]) res.push_back('{ST_FIRED, 7'(i), 1'b0});
        end
      end
      if (res.size() == 0) res.push_back('{ST_NONE, 7'd0, 1'b1});
      else res[res.size()-1].last = 1'b1;
    end else if (r.command == CMD_UNUSED || r.timer_id >= TIMER_COUNT) begin
      res.push_back('{ST_REJECT, r.timer_id, 1'b1});
    end else if (r.command == CMD_SET) begin
      deadline_mdl[r.timer_id] = r.now_ms + r.delay_ms;
      armed_mdl[r.timer_id] = 1'b1;
      handler_mdl[r.timer_id] = r.has_handler;
      res.push_back('{ST_SET_OK, r.timer_id, 1'b1});
    end else begin
      deadline_mdl[r.timer_id] = '0;
      armed_mdl[r.timer_id] = 1'b0;
      handler_mdl[r.timer_id] = 1'b0;
      res.push_back('{ST_KILL_OK, r.timer_id, 1'b1});
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(input timer_req_t r, input bit typed = 1'b0,
                          input status_e t_status = ST_NONE, input logic [6:0] t_id = '0);
    timer_rsp_t res [$];
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= r.command;
    req_if.timer_id    <= r.timer_id;
    req_if.delay_ms    <= r.delay_ms;
    req_if.now_ms      <= r.now_ms;
    req_if.has_handler <= r.has_handler;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    timer_step(r, res);
    if (typed) begin
      res.delete();
      res.push_back('{t_status, t_id, 1'b1});
    end
    foreach (res[k]) pending_rsp.push_back(res[k]);
    req_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0);
  endtask

  // Time mostly creeps forward so that polls find expired timers; now and then it jumps.
  task automatic send_random();
    timer_req_t r;
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 4) cur_now = $urandom();
    else cur_now = cur_now + 32'($urandom_range(24));
    r.now_ms = cur_now;
    case ($urandom_range(9))
      0: r.delay_ms = '0;
      1: r.delay_ms = $urandom();
      2: r.delay_ms = 32'hFFFF_FFFF;
      3: r.delay_ms = -cur_now;
      default: r.delay_ms = 32'($urandom_range(60, 1));
    endcase
    r.has_handler = ($urandom_range(3) != 0);
    r.timer_id = 7'($urandom_range(TIMER_COUNT - 1));
    if (pick < 42) begin
      r.command = CMD_SET;
    end else if (pick < 58) begin
      r.command = CMD_KILL;
    end else if (pick < 90) begin
      r.command = CMD_POLL;
      r.timer_id = 7'($urandom());
    end else if (pick < 96) begin
      r.command = pick[0] ? CMD_SET : CMD_KILL;
      r.timer_id = 7'($urandom_range(127, TIMER_COUNT));
    end else begin
      r.command = CMD_UNUSED;
      r.timer_id = 7'($urandom());
    end
    send_req(r);
  endtask

  always @(posedge clk_i) begin
    timer_rsp_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      rsp_seen++;
      if (rsp_if.status == ST_FIRED) fired_seen++;
      if (rsp_if.status == ST_REJECT) reject_seen++;
      if (pending_rsp.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: response with none expected: status %0d id %0d last %0d",
                   $realtime, rsp_if.status, rsp_if.result_id, rsp_if.last);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status || rsp_if.result_id !== want.result_id ||
            rsp_if.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: expected status %0d id %0d last %0d, got status %0d id %0d last %0d",
                     $realtime, want.status, want.result_id, want.last,
                     rsp_if.status, rsp_if.result_id, rsp_if.last);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("one_shot_timer_table test failed");
    $finish;
  end

  initial begin
    timer_req_t r;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_SET;
    req_if.timer_id = '0;
    req_if.delay_ms = '0;
    req_if.now_ms = '0;
    req_if.has_handler = 1'b0;
    rsp_if.ready = 1'b0;
    foreach (deadline_mdl[i]) begin
      deadline_mdl[i] = '0;
      armed_mdl[i] = 1'b0;
      handler_mdl[i] = 1'b0;
    end

    dir_rows = '{
      '{'{CMD_POLL,   7'd0,   32'd0,          32'd0,          1'b0}, 1'b1, ST_NONE,    7'd0},
      '{'{CMD_SET,    7'd0,   32'd10,         32'd100,        1'b1}, 1'b1, ST_SET_OK,  7'd0},
      '{'{CMD_SET,    7'd63,  32'hFFFF_FFFF,  32'd0,          1'b1}, 1'b1, ST_SET_OK,  7'd63},
      '{'{CMD_SET,    7'd64,  32'd5,          32'd5,          1'b1}, 1'b1, ST_REJECT,  7'd64},
      '{'{CMD_KILL,   7'd127, 32'd0,          32'd0,          1'b0}, 1'b1, ST_REJECT,  7'd127},
      '{'{CMD_UNUSED, 7'd5,   32'd0,          32'd0,          1'b0}, 1'b1, ST_REJECT,  7'd5},
      '{'{CMD_SET,    7'd5,   32'd1,          32'hFFFF_FFFF,  1'b1}, 1'b1, ST_SET_OK,  7'd5},
      '{'{CMD_SET,    7'd7,   32'd0,          32'd200,        1'b0}, 1'b1, ST_SET_OK,  7'd7},
      '{'{CMD_SET,    7'd1,   32'd5,          32'd100,        1'b1}, 1'b1, ST_SET_OK,  7'd1},
      '{'{CMD_POLL,   7'd0,   32'd0,          32'd105,        1'b0}, 1'b0, ST_NONE,    7'd0},
      '{'{CMD_POLL,   7'd0,   32'd0,          32'hFFFF_FFFF,  1'b0}, 1'b0, ST_NONE,    7'd0},
      '{'{CMD_POLL,   7'd0,   32'd0,          32'hFFFF_FFFF,  1'b0}, 1'b1, ST_NONE,    7'd0},
      '{'{CMD_KILL,   7'd5,   32'd0,          32'd0,          1'b0}, 1'b1, ST_KILL_OK, 7'd5},
      '{'{CMD_KILL,   7'd0,   32'd0,          32'd0,          1'b0}, 1'b1, ST_KILL_OK, 7'd0},
      '{'{CMD_POLL,   7'd127, 32'hFFFF_FFFF,  32'd0,          1'b1}, 1'b1, ST_NONE,    7'd0},
      '{'{CMD_SET,    7'd62,  32'd0,          32'd0,          1'b1}, 1'b1, ST_SET_OK,  7'd62},
      '{'{CMD_KILL,   7'd64,  32'd0,          32'd0,          1'b0}, 1'b1, ST_REJECT,  7'd64},
      '{'{CMD_SET,    7'd2,   32'h8000_0000,  32'h7FFF_FFFF,  1'b0}, 1'b1, ST_SET_OK,  7'd2},
      '{'{CMD_POLL,   7'd0,   32'd0,          32'hFFFF_FFFF,  1'b0}, 1'b0, ST_NONE,    7'd0},
      '{'{CMD_POLL,   7'd0,   32'd0,          32'hFFFF_FFFF,  1'b0}, 1'b1, ST_NONE,    7'd0}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].result_id);
    drain_responses();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      repeat (50) send_random();
      drain_responses();
    end

    // The response side holds off as the arming of every timer with a handler begins, so the
    // block backs up; the closing poll then fires the whole table at once.
    src_idle_pct = 0;
    snk_stall_pct = 20;
    cur_now = 32'd1000;
    @(posedge clk_i);
    hold_cycles = HOLD_OFF;
    @(negedge clk_i);
    for (int i = 0; i < TIMER_COUNT; i++) begin
      r = '{CMD_SET, 7'(i), 32'($urandom_range(40, 1)), cur_now, 1'b1};
      send_req(r);
    end
    r = '{CMD_POLL, 7'd0, 32'd0, cur_now + 32'd100, 1'b0};
    send_req(r);
    drain_responses();

    src_idle_pct = 10;
    snk_stall_pct = 54;
    repeat (20) send_random();
    drain_responses();
    repeat (TAIL) @(posedge clk_i);

    $display("Sent %0d requests (directed table, four idling phases, back-pressure fill).",
             req_sent);
    $display("Checked %0d responses: %0d fired, %0d rejected, %0d mismatches.",
             rsp_seen, fired_seen, reject_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("one_shot_timer_table test passed");
    end else begin
      $display("one_shot_timer_table test failed");
    end
    $finish;
  end

endmodule
